// ----- hw/rtl/mqsb_pkg.sv -----
package mqsb_pkg;

   localparam int DATA_W = 32;
   localparam int QSEL_W = 2;
   localparam int STATUS_W = 2;

   // Operation codes carried in the request.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // Value returned by a dequeue from an empty queue.
   localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = '1;

   typedef struct packed {
      logic                     operation;
      logic [QSEL_W-1:0]        queue_select;
      logic signed [DATA_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

endpackage

// ----- hw/rtl/mqsb_ram.sv -----
module mqsb_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read: data appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/multi_queue_shared_buffer.sv -----
// Several FIFO queues sharing one slot store, linked through per-slot pointers.
//
// Request channel (req_valid / req_stall / req_data): each transfer is an
// enqueue of value_in onto queue queue_select, or a dequeue from it.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one transfer per
// request, in request order, carrying the dequeued value and a status
// (ok, overflow when no slot is free, underflow when the queue is empty).
//
// Requests are handled one at a time. A rejected request goes straight from
// its transfer to the response state S_FIN; a dequeue passes through S_DEQ_RD,
// an enqueue through S_ENQ_RD and, behind a tail, S_ENQ_LINK. The single write
// port of the link memory is the reason: an enqueue behind a tail needs two link writes.
// A new request transfers in the cycle after the response is loaded; none is
// taken before the last one has loaded its response.
//
// Reset empties every queue and puts all slots on the free list; it needs no
// clearing pass because untouched slots are tracked by a fill mark. A stalled
// response is held in its output register; processing of the next request
// continues and waits only at the point where its response would be loaded.
module multi_queue_shared_buffer import mqsb_pkg::*; #(
   parameter int ENTRIES = 16,
   parameter int QUEUES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // A pointer equal to ENTRIES is the null pointer.
   localparam int PW = $clog2(ENTRIES + 1);
   localparam int AW = $clog2(ENTRIES);
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int QXW = (QW > QSEL_W) ? QW : QSEL_W;
   localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ENQ_RD = 3'd1;
   localparam logic [2:0] S_ENQ_LINK = 3'd2;
   localparam logic [2:0] S_DEQ_RD = 3'd3;
   localparam logic [2:0] S_FIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [QW-1:0] q_ff, q_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [PW-1:0] slot_ff, slot_in;
   logic [PW-1:0] tail_sv_ff, tail_sv_in;
   logic [PW-1:0] head_ff [QUEUES];
   logic [PW-1:0] head_in [QUEUES];
   logic [PW-1:0] tail_ff [QUEUES];
   logic [PW-1:0] tail_in [QUEUES];
   logic [PW-1:0] free_head_ff, free_head_in;
   // Fill mark: slots at or above it have never been handed out, so their
   // link is implicitly the next slot and the link memory needs no init.
   logic [PW-1:0] mark_ff, mark_in;
   logic [DATA_W-1:0] res_val_ff, res_val_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic link_wr_en, link_rd_en;
   logic [AW-1:0] link_wr_addr, link_rd_addr;
   logic [PW-1:0] link_wr_data, link_rd_data;
   logic data_wr_en, data_rd_en;
   logic [AW-1:0] data_wr_addr, data_rd_addr;
   logic [DATA_W-1:0] data_wr_data, data_rd_data;

   logic [QXW-1:0] req_q_ext;
   logic req_q_ok;
   logic [QW-1:0] q_sel;
   logic [PW-1:0] head_sel, tail_sel;
   logic untouched;

   function automatic logic ptr_ok(input logic [PW-1:0] p);
      return p < NULL_PTR;
   endfunction

   mqsb_ram #(.DEPTH(ENTRIES), .WIDTH(PW), .AW(AW)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   mqsb_ram #(.DEPTH(ENTRIES), .WIDTH(DATA_W), .AW(AW)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_data)
   );

   // The request is only taken while the sequencer is idle. Because one
   // request is finished before the next is taken, no memory access can
   // overlap a pending write to the same entry.
   assign req_stall = (state_ff != S_IDLE);

   assign req_q_ext = QXW'(req_data.queue_select);
   assign req_q_ok = (32'(req_data.queue_select) < 32'(QUEUES));
   assign q_sel = (state_ff == S_IDLE) ? req_q_ext[QW-1:0] : q_ff;
   assign head_sel = head_ff[q_sel];
   assign tail_sel = tail_ff[q_sel];
   assign untouched = (slot_ff >= mark_ff);

   always_comb begin
      state_in = state_ff;
      q_in = q_ff;
      val_in = val_ff;
      slot_in = slot_ff;
      tail_sv_in = tail_sv_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      free_head_in = free_head_ff;
      mark_in = mark_ff;
      res_val_in = res_val_ff;
      res_st_in = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      link_wr_en = 1'b0;
      link_wr_addr = slot_ff[AW-1:0];
      link_wr_data = NULL_PTR;
      link_rd_en = 1'b0;
      link_rd_addr = free_head_ff[AW-1:0];
      data_wr_en = 1'b0;
      data_wr_addr = slot_ff[AW-1:0];
      data_wr_data = val_ff;
      data_rd_en = 1'b0;
      data_rd_addr = head_sel[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_in = req_q_ext[QW-1:0];
               val_in = req_data.value_in;
               res_val_in = '0;
               res_st_in = ST_OK;
               if (req_data.operation == OP_ENQUEUE) begin
                  if (!req_q_ok || !ptr_ok(free_head_ff)) begin
                     res_st_in = ST_OVERFLOW;
                     state_in = S_FIN;
                  end else begin
                     // Fetch the successor of the free-list head.
                     slot_in = free_head_ff;
                     link_rd_en = 1'b1;
                     link_rd_addr = free_head_ff[AW-1:0];
                     state_in = S_ENQ_RD;
                  end
               end else begin
                  if (!req_q_ok || !ptr_ok(head_sel)) begin
                     res_st_in = ST_UNDERFLOW;
                     res_val_in = UNDERFLOW_VALUE;
                     state_in = S_FIN;
                  end else begin
                     // Fetch the head slot's successor and its value.
                     slot_in = head_sel;
                     link_rd_en = 1'b1;
                     link_rd_addr = head_sel[AW-1:0];
                     data_rd_en = 1'b1;
                     data_rd_addr = head_sel[AW-1:0];
                     state_in = S_DEQ_RD;
                  end
               end
            end
         end
         S_ENQ_RD: begin
            // Pop the slot from the free list.
            if (untouched) begin
               free_head_in = slot_ff + PW'(1);
               mark_in = mark_ff + PW'(1);
            end else begin
               free_head_in = link_rd_data;
            end
            // The new slot becomes the end of the queue.
            link_wr_en = 1'b1;
            link_wr_addr = slot_ff[AW-1:0];
            link_wr_data = NULL_PTR;
            data_wr_en = 1'b1;
            data_wr_addr = slot_ff[AW-1:0];
            data_wr_data = val_ff;
            tail_in[q_ff] = slot_ff;
            if (!ptr_ok(head_sel)) begin
               head_in[q_ff] = slot_ff;
               state_in = S_FIN;
            end else if (ptr_ok(tail_sel)) begin
               tail_sv_in = tail_sel;
               state_in = S_ENQ_LINK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_ENQ_LINK: begin
            // Chain the old tail to the new slot.
            link_wr_en = 1'b1;
            link_wr_addr = tail_sv_ff[AW-1:0];
            link_wr_data = slot_ff;
            state_in = S_FIN;
         end
         S_DEQ_RD: begin
            // Unlink the head and push its slot onto the free list.
            head_in[q_ff] = link_rd_data;
            link_wr_en = 1'b1;
            link_wr_addr = slot_ff[AW-1:0];
            link_wr_data = free_head_ff;
            free_head_in = slot_ff;
            res_val_in = data_rd_data;
            state_in = S_FIN;
         end
         S_FIN: begin
            // Load the response once the output register is free or draining.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.value_out = res_val_ff;
               rsp_data_in.status = res_st_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_head_ff <= '0;
         mark_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= NULL_PTR;
            tail_ff[i] <= NULL_PTR;
         end
      end else begin
         state_ff <= state_in;
         free_head_ff <= free_head_in;
         mark_ff <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      val_ff <= val_in;
      slot_ff <= slot_in;
      tail_sv_ff <= tail_sv_in;
      res_val_ff <= res_val_in;
      res_st_ff <= res_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- hw/rtl/mqsb_checker.sv -----
module mqsb_checker import mqsb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A response that is stalled stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its contents.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // One request at a time: after a transfer the request side is stalled.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in progress");

   // Underflow always returns all ones, overflow returns zero.
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status != ST_UNDERFLOW)
                     || (rsp_data.value_out == UNDERFLOW_VALUE))
                 && ((rsp_data.status != ST_OVERFLOW) || (rsp_data.value_out == '0)))
      else $error("error response with wrong value");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK) || (rsp_data.status == ST_OVERFLOW)
                    || (rsp_data.status == ST_UNDERFLOW))
      else $error("undefined status code");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
